FILE: src/assert_macros.svh
// Assertion macros shared by the short file name parser RTL.
// Standalone header; the including module must provide clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define SFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define SFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: src/sfp_pkg.sv
// Types and constants for the short (8.3) file name parser.
// No dependencies; used by sfp_char_class and short_filename_parser_top.
package sfp_pkg;

  localparam int unsigned NAME_CHARS = 8;
  localparam int unsigned EXT_CHARS  = 3;

  localparam int unsigned NAME_BYTES = 8;
  localparam int unsigned EXT_BYTES  = 3;
  localparam int unsigned COUNT_W    = 4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_DIG_0 = 8'h30;
  localparam logic [7:0] CH_DIG_9 = 8'h39;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [COUNT_W-1:0] NAME_LIMIT = COUNT_W'(NAME_CHARS);
  localparam logic [COUNT_W-1:0] EXT_LIMIT  = COUNT_W'(EXT_CHARS);

  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_NAME  = 3'd1,
    PH_EXT   = 3'd2,
    PH_TRAIL = 3'd3,
    PH_ERR   = 3'd4
  } phase_e;

  typedef struct packed {
    logic       term;
    logic       blank;
    logic       dot;
    logic       legal;
    logic [7:0] upper;
  } char_class_t;

endpackage

FILE: src/sfp_char_class.sv
// Character classifier for the short file name parser: folds case and flags
// terminator, blanks, dot and legal name characters. Depends on sfp_pkg.
module sfp_char_class import sfp_pkg::*; (
  input  logic [7:0]  char_i,
  output char_class_t class_o
);

  logic [7:0] folded;

  always_comb begin
    if (char_i >= CH_LO_A && char_i <= CH_LO_Z) begin
      folded = char_i - CASE_OFS;
    end else begin
      folded = char_i;
    end
  end

  always_comb begin
    class_o.term  = (char_i == CH_NUL);
    class_o.blank = (char_i == CH_SPACE) || (char_i == CH_TAB);
    class_o.dot   = (char_i == CH_DOT);
    class_o.legal = (folded >= CH_UP_A && folded <= CH_UP_Z) ||
                    (folded >= CH_DIG_0 && folded <= CH_DIG_9) ||
                    (folded == CH_UNDER) || (folded == CH_DASH);
    class_o.upper = folded;
  end

endmodule

FILE: src/short_filename_parser_top.sv
// Top level of the short (8.3) file name parser.
// Depends on sfp_pkg, sfp_char_class and assert_macros.svh.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------
//  input   | in        | in_valid_i / in_stall_o    | char_in_i
//  result  | out       | out_valid_o / out_stall_i  | name_ok_o, base_name_o, extension_o
//
// One character is taken every cycle while in_stall_o is low; the parse state
// updates in the same cycle and a result appears in the output register in the
// cycle after the terminating zero byte is taken. Reset puts the parser in the
// leading blank phase with space-filled buffers and an empty output register.
// While a result is held by out_stall_i, ordinary characters are still taken;
// only a further terminator is stalled until the held result leaves.
`include "assert_macros.svh"

module short_filename_parser_top import sfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        name_ok_o,
  output logic [63:0] base_name_o,
  output logic [23:0] extension_o
);

  localparam logic [NAME_BYTES-1:0][7:0] NAME_BLANK = {NAME_BYTES{CH_SPACE}};
  localparam logic [EXT_BYTES-1:0][7:0]  EXT_BLANK  = {EXT_BYTES{CH_SPACE}};

  char_class_t cls;

  phase_e                        phase_q, phase_d;
  logic [COUNT_W-1:0]            count_q, count_d;
  logic [NAME_BYTES-1:0][7:0]    name_q, name_d;
  logic [EXT_BYTES-1:0][7:0]     ext_q, ext_d;

  logic                          out_valid_q, out_valid_d;
  logic                          ok_q;
  logic [63:0]                   base_q;
  logic [23:0]                   ext_out_q;

  logic                          in_accept;
  logic                          out_hold;
  logic                          result_ok;

  sfp_char_class u_class (
    .char_i  (char_in_i),
    .class_o (cls)
  );

  assign out_hold   = out_valid_q && out_stall_i;
  assign in_stall_o = out_hold && cls.term;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign result_ok  = (phase_q == PH_NAME) || (phase_q == PH_EXT) || (phase_q == PH_TRAIL);

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    name_d  = name_q;
    ext_d   = ext_q;

    if (in_accept) begin
      if (cls.term) begin
        phase_d = PH_LEAD;
        count_d = '0;
        name_d  = NAME_BLANK;
        ext_d   = EXT_BLANK;
      end else begin
        case (phase_q)
          PH_LEAD: begin
            if (cls.blank) begin
              phase_d = PH_LEAD;
            end else if (cls.dot || !cls.legal || count_q >= NAME_LIMIT) begin
              phase_d = PH_ERR;
            end else begin
              name_d[count_q[2:0]] = cls.upper;
              count_d = count_q + 1'b1;
              phase_d = PH_NAME;
            end
          end
          PH_NAME: begin
            if (cls.dot) begin
              phase_d = PH_EXT;
              count_d = '0;
            end else if (cls.blank) begin
              phase_d = PH_TRAIL;
            end else if (!cls.legal || count_q >= NAME_LIMIT) begin
              phase_d = PH_ERR;
            end else begin
              name_d[count_q[2:0]] = cls.upper;
              count_d = count_q + 1'b1;
            end
          end
          PH_EXT: begin
            // A second dot is not a legal character and ends in error here.
            if (cls.blank) begin
              phase_d = PH_TRAIL;
            end else if (!cls.legal || count_q >= EXT_LIMIT) begin
              phase_d = PH_ERR;
            end else begin
              ext_d[count_q[1:0]] = cls.upper;
              count_d = count_q + 1'b1;
            end
          end
          PH_TRAIL: begin
            if (!cls.blank) begin
              phase_d = PH_ERR;
            end
          end
          default: begin
            phase_d = PH_ERR;
          end
        endcase
      end
    end
  end

  assign out_valid_d = (in_accept && cls.term) || out_hold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEAD;
      count_q     <= '0;
      name_q      <= NAME_BLANK;
      ext_q       <= EXT_BLANK;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      name_q      <= name_d;
      ext_q       <= ext_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && cls.term) begin
      ok_q      <= result_ok;
      base_q    <= result_ok ? name_q : '0;
      ext_out_q <= result_ok ? ext_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign name_ok_o   = ok_q;
  assign base_name_o = base_q;
  assign extension_o = ext_out_q;

  `SFP_ASSERT(a_bad_name_zero, (out_valid_q && !ok_q) |-> (base_q == '0 && ext_out_q == '0), "invalid result carries nonzero name")
  `SFP_ASSERT(a_term_restarts, (in_accept && cls.term) |=> (out_valid_q && phase_q == PH_LEAD && count_q == '0), "terminator did not restart the parser")
  `SFP_ASSERT(a_no_spurious, (in_accept && !cls.term && !out_hold) |=> !out_valid_q, "result without a terminator")
  `SFP_ASSERT_ALWAYS(a_ok_nonempty, (out_valid_q && ok_q) |-> (base_q[7:0] != CH_SPACE), "valid result with empty base name")

endmodule
